>>> rtl/spiq_pkg.sv
// Shared types and codes for the stable priority insert queue.
package spiq_pkg;

  localparam int unsigned PRIO_WIDTH   = 3;
  localparam int unsigned STATUS_WIDTH = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LIST   = 1'b1;

  localparam logic [STATUS_WIDTH-1:0] STATUS_INSERTED = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_LISTED   = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [STATUS_WIDTH-1:0] STATUS_FULL     = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_PLACE = 5'b00100,
    ST_RESP  = 5'b01000,
    ST_LIST  = 5'b10000
  } spiq_state_e;

endpackage

>>> rtl/spiq_mem.sv
// Entry store: one write port and one read port with registered read data.
module spiq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 19
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/stable_priority_insert_queue.sv
// Top level of the stable priority insert queue: control sequencer and result register.
//
// The queue keeps up to DEPTH entries (tag and 3-bit priority) in one
// synchronous RAM, ordered by descending priority with equal priorities in
// arrival order. A request is taken only while the sequencer is idle; the
// result register in front of the output lets a new request be taken while
// the previous result still waits. An insert into a queue holding n entries
// walks the store from the tail, one entry per cycle through the single read
// port, moving each lower-priority entry up by one and writing the new entry
// behind the first entry of greater or equal priority, then hands over its
// result. An insert into a full queue is dropped with a full status. A list
// streams the n entries from the registered read port at one per cycle while
// the output does not stall, and answers an empty queue with a single empty
// status. Output stalls hold back the list stream and the hand-over of each
// result, but not the insert walk. The store is not cleared after reset; only
// the entry count is.
module stable_priority_insert_queue
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned TAG_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic [TAG_WIDTH-1:0]               entry_tag_i,
  input  logic [spiq_pkg::PRIO_WIDTH-1:0]    entry_priority_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [spiq_pkg::STATUS_WIDTH-1:0]  status_o,
  output logic [TAG_WIDTH-1:0]               out_tag_o,
  output logic [spiq_pkg::PRIO_WIDTH-1:0]    out_priority_o,
  output logic                               last_o
);

  import spiq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = TAG_WIDTH + PRIO_WIDTH;

  spiq_state_e state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  logic [TAG_WIDTH-1:0] new_tag_q;
  logic [PRIO_WIDTH-1:0] new_pri_q;
  logic [STATUS_WIDTH-1:0] resp_q, resp_d;

  logic out_valid_q, out_valid_d;
  logic [STATUS_WIDTH-1:0] status_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic [PRIO_WIDTH-1:0] pri_q;
  logic last_q;

  // store port signals
  logic re, we;
  logic [AW-1:0] raddr, waddr;
  logic [EW-1:0] wdata, rdata;
  logic [TAG_WIDTH-1:0] rd_tag;
  logic [PRIO_WIDTH-1:0] rd_pri;

  // result register load
  logic load;
  logic [STATUS_WIDTH-1:0] ld_status;
  logic [TAG_WIDTH-1:0] ld_tag;
  logic [PRIO_WIDTH-1:0] ld_pri;
  logic ld_last;

  logic accept, out_free, list_last;

  spiq_mem #(
    .DEPTH(DEPTH),
    .WIDTH(EW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_tag = rdata[TAG_WIDTH-1:0];
  assign rd_pri = rdata[EW-1:TAG_WIDTH];

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign list_last  = ((CW'(idx_q) + CW'(1)) == count_q);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    resp_d    = resp_q;
    re        = 1'b0;
    raddr     = idx_q;
    we        = 1'b0;
    waddr     = '0;
    wdata     = {new_pri_q, new_tag_q};
    load      = 1'b0;
    ld_status = resp_q;
    ld_tag    = '0;
    ld_pri    = '0;
    ld_last   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_INSERT) begin
            resp_d = STATUS_INSERTED;
            if (count_q == CW'(DEPTH)) begin
              // drop the entry, store untouched
              resp_d  = STATUS_FULL;
              state_d = ST_RESP;
            end else if (count_q == '0) begin
              state_d = ST_PLACE;
            end else begin
              // start the tail walk at the last stored entry
              re      = 1'b1;
              raddr   = AW'(count_q - CW'(1));
              idx_d   = AW'(count_q - CW'(1));
              state_d = ST_SCAN;
            end
          end else begin
            if (count_q == '0) begin
              resp_d  = STATUS_EMPTY;
              state_d = ST_RESP;
            end else begin
              re      = 1'b1;
              raddr   = '0;
              idx_d   = '0;
              state_d = ST_LIST;
            end
          end
        end
      end

      ST_SCAN: begin
        // entry idx_q is on the read port; fetch the one below it ahead of time
        if (idx_q != '0) begin
          re    = 1'b1;
          raddr = idx_q - AW'(1);
        end
        we    = 1'b1;
        waddr = idx_q + AW'(1);
        if (rd_pri < new_pri_q) begin
          // shift the lower-priority entry up one place
          wdata = rdata;
          if (idx_q == '0) begin
            state_d = ST_PLACE;
          end else begin
            idx_d = idx_q - AW'(1);
          end
        end else begin
          // land behind the first entry of greater or equal priority
          count_d = count_q + CW'(1);
          state_d = ST_RESP;
        end
      end

      ST_PLACE: begin
        we      = 1'b1;
        waddr   = '0;
        count_d = count_q + CW'(1);
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_LIST: begin
        // read data holds while the output stalls
        if (out_free) begin
          load      = 1'b1;
          ld_status = STATUS_LISTED;
          ld_tag    = rd_tag;
          ld_pri    = rd_pri;
          ld_last   = list_last;
          if (list_last) begin
            state_d = ST_IDLE;
          end else begin
            re    = 1'b1;
            raddr = idx_q + AW'(1);
            idx_d = idx_q + AW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      resp_q      <= STATUS_INSERTED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      resp_q      <= resp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request payload and the result payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      new_tag_q <= entry_tag_i;
      new_pri_q <= entry_priority_i;
    end
    if (load) begin
      status_q <= ld_status;
      tag_q    <= ld_tag;
      pri_q    <= ld_pri;
      last_q   <= ld_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_tag_o      = tag_q;
  assign out_priority_o = pri_q;
  assign last_o         = last_q;

endmodule

>>> verif/spiq_queue_checker.sv
// Checker for the stable priority insert queue: predicts and compares every result.
module spiq_queue_checker #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned TAG_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              operation_i,
  input  logic [TAG_WIDTH-1:0]              entry_tag_i,
  input  logic [spiq_pkg::PRIO_WIDTH-1:0]   entry_priority_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [spiq_pkg::STATUS_WIDTH-1:0] status_i,
  input  logic [TAG_WIDTH-1:0]              out_tag_i,
  input  logic [spiq_pkg::PRIO_WIDTH-1:0]   out_priority_i,
  input  logic                              last_i,
  output int unsigned                       error_count_o,
  output int unsigned                       pending_o
);

  import spiq_pkg::*;

  typedef struct packed {
    logic [STATUS_WIDTH-1:0] status;
    logic [TAG_WIDTH-1:0]    tag;
    logic [PRIO_WIDTH-1:0]   prio;
    logic                    last;
  } queue_result_t;

  logic [TAG_WIDTH-1:0]  queued_tag  [DEPTH];
  logic [PRIO_WIDTH-1:0] queued_prio [DEPTH];
  int                    queued_count;
  queue_result_t         awaited_results [$];
  queue_result_t         awaited;
  int unsigned           mismatch_count;

  // Update the ordered copy of the store and queue the results of one request.
  function automatic void predict_request(input logic op, input logic [TAG_WIDTH-1:0] tag,
                                          input logic [PRIO_WIDTH-1:0] prio);
    int            slot;
    queue_result_t res;
    res      = '0;
    res.last = 1'b1;
    if (op == OP_INSERT) begin
      if (queued_count >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        // land behind every entry of greater or equal priority
        slot = 0;
        while (slot < queued_count && queued_prio[slot] >= prio) slot++;
        for (int i = queued_count; i > slot; i--) begin
          queued_tag[i]  = queued_tag[i-1];
          queued_prio[i] = queued_prio[i-1];
        end
        queued_tag[slot]  = tag;
        queued_prio[slot] = prio;
        queued_count++;
        res.status = STATUS_INSERTED;
      end
      awaited_results.push_back(res);
    end else if (queued_count == 0) begin
      res.status = STATUS_EMPTY;
      awaited_results.push_back(res);
    end else begin
      for (int i = 0; i < queued_count; i++) begin
        res.status = STATUS_LISTED;
        res.tag    = queued_tag[i];
        res.prio   = queued_prio[i];
        res.last   = (i == queued_count - 1);
        awaited_results.push_back(res);
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_count   = 0;
      mismatch_count = 0;
      awaited_results.delete();
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h %0h %0h %0b",
                   $time, status_i, out_tag_i, out_priority_i, last_i);
          mismatch_count++;
        end else begin
          awaited = awaited_results.pop_front();
          check_field("status", 32'(awaited.status), 32'(status_i));
          check_field("out_tag", 32'(awaited.tag), 32'(out_tag_i));
          check_field("out_priority", 32'(awaited.prio), 32'(out_priority_i));
          check_field("last", 32'(awaited.last), 32'(last_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_request(operation_i, entry_tag_i, entry_priority_i);
      end
      error_count_o <= mismatch_count;
      pending_o     <= awaited_results.size();
    end
  end

endmodule

>>> verif/stable_priority_insert_queue_test.sv
// Testbench top for the stable priority insert queue: stimulus, output stalls and verdict.
module stable_priority_insert_queue_test;
  import spiq_pkg::*;

  localparam int unsigned DEPTH          = 64;
  localparam int unsigned TAG_WIDTH      = 16;
  localparam int unsigned RANDOM_ITEMS   = 310;
  localparam int unsigned WAIT_MAX       = 14;
  // longest quiet stretch is an insert walking a store of DEPTH - 1 entries plus both waits
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = DEPTH + 16;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    operation_i;
  logic [TAG_WIDTH-1:0]    entry_tag_i;
  logic [PRIO_WIDTH-1:0]   entry_priority_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [STATUS_WIDTH-1:0] status_o;
  logic [TAG_WIDTH-1:0]    out_tag_o;
  logic [PRIO_WIDTH-1:0]   out_priority_o;
  logic                    last_o;

  int unsigned mismatches;
  int unsigned results_pending;
  int unsigned quiet_cycles;
  int unsigned inserts_sent;
  bit          source_calm;
  bit          sink_calm;

  always #6 clk_i = ~clk_i;

  stable_priority_insert_queue #(
    .DEPTH    (DEPTH),
    .TAG_WIDTH(TAG_WIDTH)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .entry_tag_i     (entry_tag_i),
    .entry_priority_i(entry_priority_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .out_tag_o       (out_tag_o),
    .out_priority_o  (out_priority_o),
    .last_o          (last_o)
  );

  spiq_queue_checker #(
    .DEPTH    (DEPTH),
    .TAG_WIDTH(TAG_WIDTH)
  ) checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .operation_i     (operation_i),
    .entry_tag_i     (entry_tag_i),
    .entry_priority_i(entry_priority_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status_o),
    .out_tag_i       (out_tag_o),
    .out_priority_i  (out_priority_o),
    .last_i          (last_o),
    .error_count_o   (mismatches),
    .pending_o       (results_pending)
  );

  // Issue one request: wait a random gap, then hold it steady until taken.
  // Valid stays high on return so back-to-back requests need no bubble.
  task automatic send_request(input logic op, input logic [TAG_WIDTH-1:0] tag,
                              input logic [PRIO_WIDTH-1:0] prio);
    int unsigned gap;
    // flip between bursty and idle-heavy stretches now and then
    if ($urandom_range(0, 15) == 0) source_calm = !source_calm;
    gap = source_calm ? 0 : $urandom_range(0, WAIT_MAX);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    entry_tag_i      <= tag;
    entry_priority_i <= prio;
    do @(posedge clk_i); while (in_stall_o);
    if (op == OP_INSERT) inserts_sent++;
  endtask

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("stable_priority_insert_queue_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: stall for a random number of cycles before each result,
  // so the stall lands on every phase of an insert walk and a list stream.
  initial begin : result_sink
    int unsigned hold;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
      hold = sink_calm ? 0 : $urandom_range(0, WAIT_MAX);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : request_source
    logic                  op;
    logic [TAG_WIDTH-1:0]  tag;
    logic [PRIO_WIDTH-1:0] prio;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    operation_i      <= OP_INSERT;
    entry_tag_i      <= '0;
    entry_priority_i <= '0;
    inserts_sent     = 0;
    source_calm      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: list an empty queue, then the field extremes and
    // equal-priority ties at the head, the middle and the tail.
    send_request(OP_LIST, 16'hFFFF, 3'd7);
    send_request(OP_INSERT, 16'h0000, 3'd0);
    send_request(OP_INSERT, 16'hFFFF, 3'd7);
    send_request(OP_INSERT, 16'h1234, 3'd3);
    send_request(OP_INSERT, 16'h5678, 3'd3);
    send_request(OP_INSERT, 16'hAAAA, 3'd7);
    send_request(OP_INSERT, 16'h5555, 3'd0);
    send_request(OP_LIST, 16'h0000, 3'd0);
    send_request(OP_INSERT, 16'h0F0F, 3'd5);
    send_request(OP_INSERT, 16'hF0F0, 3'd1);
    send_request(OP_INSERT, 16'h8001, 3'd3);
    send_request(OP_LIST, 16'h7FFE, 3'd4);

    // Random: mostly inserts until the store fills up, then an even mix of
    // full-queue drops and complete listings. Nothing ever leaves the queue,
    // so the full case is reached only here.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (inserts_sent >= DEPTH) begin
        op = ($urandom_range(0, 1) == 0) ? OP_LIST : OP_INSERT;
      end else begin
        op = ($urandom_range(0, 7) == 0) ? OP_LIST : OP_INSERT;
      end
      tag  = TAG_WIDTH'($urandom);
      prio = PRIO_WIDTH'($urandom_range(0, 7));
      send_request(op, tag, prio);
    end
    in_valid_i <= 1'b0;

    // Drain, then give the block time to show any stray result.
    do @(posedge clk_i); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && results_pending == 0) begin
      $display("stable_priority_insert_queue_test: clean");
    end else begin
      $display("stable_priority_insert_queue_test: errors");
    end
    $finish;
  end

endmodule
